FILE: sv/pee_pkg.sv
`default_nettype none
package pee_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int FRAC_BITS       = 16;
  localparam int VAL_W           = 48;

  typedef logic [2:0] op_t;
  localparam op_t OP_PUSH = 3'd0;
  localparam op_t OP_ADD  = 3'd1;
  localparam op_t OP_SUB  = 3'd2;
  localparam op_t OP_MUL  = 3'd3;
  localparam op_t OP_DIV  = 3'd4;
  localparam op_t OP_END  = 3'd5;
  localparam op_t OP_BAD  = 3'd6;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_UNDER = 3'd1;
  localparam status_t ST_OVER  = 3'd2;
  localparam status_t ST_DIVZ  = 3'd3;
  localparam status_t ST_BADCH = 3'd4;
  localparam status_t ST_SAT   = 3'd5;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_stream_t;

endpackage
`default_nettype wire

FILE: sv/pee_stream_if.sv
`default_nettype none
interface pee_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source (output valid, char_code, input ready);
  modport sink   (input valid, char_code, output ready);
endinterface

interface pee_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] value;
  logic [2:0]         status;
  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface
`default_nettype wire

FILE: sv/pee_ram.sv
`default_nettype none
module pee_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/pee_front.sv
`default_nettype none
module pee_front (
  input  logic                 clk,
  input  logic                 rst,
  pee_char_if.sink             chars,
  output pee_pkg::cmd_stream_t cmd_q,
  input  logic                 cmd_pop
);
  import pee_pkg::*;

  cmd_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cls;

  function automatic cmd_t classify(input logic [7:0] c);
    cmd_t r;
    r.digit = 4'd0;
    if (c == CH_END) begin
      r.op = OP_END;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      r.op    = OP_PUSH;
      r.digit = 4'(c - CH_ZERO);
    end else if (c == CH_PLUS) begin
      r.op = OP_ADD;
    end else if (c == CH_MINUS) begin
      r.op = OP_SUB;
    end else if (c == CH_STAR) begin
      r.op = OP_MUL;
    end else if (c == CH_SLASH) begin
      r.op = OP_DIV;
    end else begin
      r.op = OP_BAD;
    end
    return r;
  endfunction

  assign chars.ready = (count != 2'd2);
  assign push        = chars.valid && chars.ready;
  assign cls         = classify(chars.char_code);
  assign cmd_q.valid = (count != 2'd0);
  assign cmd_q.cmd   = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= cls;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (cmd_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> count != 2'd0) else $error("pop from empty queue");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("push into full queue");
endmodule
`default_nettype wire

FILE: sv/pee_back.sv
`default_nettype none
module pee_back #(
  parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pee_pkg::cmd_stream_t cmd_q,
  output logic                 cmd_pop,
  pee_result_if.source         results
);
  import pee_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SAT  = 3'd4;

  localparam logic [63:0] POS_LIM = 64'h0000_7fff_ffff_ffff;
  localparam logic [63:0] NEG_LIM = 64'h0000_8000_0000_0000;

  logic [2:0]         state;
  logic [SP_W-1:0]    sp;
  logic [SP_W-1:0]    sp_m1;
  logic [SP_W-1:0]    sp_m2;
  status_t            err;
  logic signed [47:0] tos;
  op_t                opr;
  logic [47:0]        ma;
  logic [47:0]        mb;
  logic               res_neg;
  logic [63:0]        res_mag;
  logic [95:0]        acc;
  logic [1:0]         pcnt;
  logic [47:0]        rem;
  logic [63:0]        quo;
  logic [5:0]         dcnt;

  logic               out_space;
  logic               ram_we;
  logic [47:0]        ram_rdata;
  logic signed [47:0] lhs;
  logic [48:0]        sum;
  logic [48:0]        sum_mag;
  logic [23:0]        pa;
  logic [23:0]        pb;
  logic [47:0]        pp;
  logic [95:0]        pp_sh;
  logic [95:0]        acc_next;
  logic [48:0]        rem_sh;
  logic [48:0]        rem_diff;
  logic               ge;
  logic               sat;
  logic [47:0]        sat_val;

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  assign sp_m1     = sp - SP_W'(1);
  assign sp_m2     = sp - SP_W'(2);
  assign out_space = !results.valid || results.ready;
  assign cmd_pop   = (state == S_IDLE) && cmd_q.valid
                     && (cmd_q.cmd.op != OP_END || out_space);
  assign ram_we    = cmd_pop && cmd_q.cmd.op == OP_PUSH
                     && sp < SP_W'(STACK_DEPTH) && sp != '0;

  pee_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp_m1[AW-1:0]),
    .wdata (tos),
    .raddr (sp_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign lhs = ram_rdata;
  always_comb begin
    if (opr == OP_SUB) begin
      sum = {lhs[47], lhs} - {tos[47], tos};
    end else begin
      sum = {lhs[47], lhs} + {tos[47], tos};
    end
    sum_mag = sum[48] ? -sum : sum;
  end

  assign pa       = pcnt[1] ? ma[47:24] : ma[23:0];
  assign pb       = pcnt[0] ? mb[47:24] : mb[23:0];
  assign pp       = pa * pb;
  assign pp_sh    = {48'd0, pp} << (7'(pcnt[1]) + 7'(pcnt[0])) * 7'd24;
  assign acc_next = acc + pp_sh;

  assign rem_sh   = {rem, quo[63]};
  assign rem_diff = rem_sh - {1'b0, mb};
  assign ge       = !rem_diff[48];

  always_comb begin
    if (res_neg) begin
      sat     = res_mag > NEG_LIM;
      sat_val = sat ? NEG_LIM[47:0] : 48'(-res_mag);
    end else begin
      sat     = res_mag > POS_LIM;
      sat_val = sat ? POS_LIM[47:0] : res_mag[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sp            <= '0;
      err           <= ST_OK;
      results.valid <= 1'b0;
    end else begin
      if (results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd_q.cmd.op)
              OP_PUSH: begin
                if (sp >= SP_W'(STACK_DEPTH)) begin
                  if (err == ST_OK) err <= ST_OVER;
                end else begin
                  tos <= 48'(cmd_q.cmd.digit) << FRAC_BITS;
                  sp  <= sp + SP_W'(1);
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (sp < SP_W'(2)) begin
                  if (err == ST_OK) err <= ST_UNDER;
                end else begin
                  opr   <= cmd_q.cmd.op;
                  state <= S_READ;
                end
              end
              OP_END: begin
                results.valid  <= 1'b1;
                results.value  <= (sp == '0) ? '0 : tos;
                results.status <= (sp == '0 && err == ST_OK) ? ST_UNDER : err;
                sp             <= '0;
                err            <= ST_OK;
              end
              default: begin
                if (err == ST_OK) err <= ST_BADCH;
              end
            endcase
          end
        end
        S_READ: begin
          res_neg <= lhs[47] ^ tos[47];
          ma      <= mag48(lhs);
          mb      <= mag48(tos);
          unique case (opr)
            OP_MUL: begin
              acc   <= '0;
              pcnt  <= 2'd0;
              state <= S_MUL;
            end
            OP_DIV: begin
              if (tos == '0) begin
                if (err == ST_OK) err <= ST_DIVZ;
                tos   <= '0;
                sp    <= sp_m1;
                state <= S_IDLE;
              end else begin
                rem   <= '0;
                quo   <= {mag48(lhs), 16'd0};
                dcnt  <= 6'd0;
                state <= S_DIV;
              end
            end
            default: begin
              res_neg <= sum[48];
              res_mag <= {15'd0, sum_mag};
              state   <= S_SAT;
            end
          endcase
        end
        S_MUL: begin
          acc  <= acc_next;
          pcnt <= pcnt + 2'd1;
          if (pcnt == 2'd3) begin
            res_mag <= (|acc_next[95:80]) ? '1 : acc_next[79:16];
            state   <= S_SAT;
          end
        end
        S_DIV: begin
          rem  <= ge ? rem_diff[47:0] : rem_sh[47:0];
          quo  <= {quo[62:0], ge};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) begin
            res_mag <= {quo[62:0], ge};
            state   <= S_SAT;
          end
        end
        S_SAT: begin
          if (sat && err == ST_OK) err <= ST_SAT;
          tos   <= sat_val;
          sp    <= sp_m1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH)) else $error("stack pointer out of range");
  a_busy_no_pop: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !cmd_pop) else $error("pop while busy");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    cmd_pop && cmd_q.cmd.op == OP_END |=> sp == '0 && err == ST_OK && results.valid)
    else $error("end of expression did not clear");
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    err != ST_OK && !(cmd_pop && cmd_q.cmd.op == OP_END) |=> err == $past(err))
    else $error("error status overwritten");
  a_op_depth: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> sp >= SP_W'(2)) else $error("operator without two operands");
endmodule
`default_nettype wire

FILE: sv/postfix_expression_evaluator.sv
// channel  | dir | payload                          | handshake
// chars    | in  | char_code[7:0]                   | valid/ready
// results  | out | value[47:0] signed Q31.16, status | valid/ready
//
// A 2-entry queue takes one character per cycle when not full, also while the executor works.
// Digit, bad character, end: idle only. + and -: read, then saturate. *: a multiply
// state between (four 24x24 partial products). /: a restoring divide state, 1 bit/cycle.
// Stack below the top lives in a RAM with registered read; the top is a register.
// rst (synchronous) empties the stack and clears the error status.
// An end character waits in the queue while the previous result is untaken.
`default_nettype none
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pee_char_if.sink     chars,
  pee_result_if.source results
);
  import pee_pkg::*;

  cmd_stream_t cmd_q;
  logic        cmd_pop;

  pee_front u_front (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .cmd_q   (cmd_q),
    .cmd_pop (cmd_pop)
  );

  pee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cmd_q   (cmd_q),
    .cmd_pop (cmd_pop),
    .results (results)
  );
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import pee_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam logic [63:0] POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM = 64'h0000_8000_0000_0000;

  typedef struct {
    logic signed [47:0] value;
    status_t            status;
  } rpn_result_t;

  class rpn_scoreboard;
    logic signed [47:0] stk [DEPTH];
    int                 sp;
    status_t            err;
    rpn_result_t        pending[$];
    int                 errors;

    function new();
      sp = 0;
      err = ST_OK;
      errors = 0;
    endfunction

    function void flag(status_t s);
      if (err == ST_OK) err = s;
    endfunction

    function logic [63:0] mag(logic signed [47:0] v);
      logic signed [63:0] w;
      w = v;
      return w < 0 ? -w : w;
    endfunction

    function logic signed [47:0] from_sm(bit neg, logic [63:0] m);
      if (neg) begin
        if (m > NEG_LIM) begin
          flag(ST_SAT);
          m = NEG_LIM;
        end
        return 48'(-m);
      end
      if (m > POS_LIM) begin
        flag(ST_SAT);
        m = POS_LIM;
      end
      return 48'(m);
    endfunction

    function logic signed [47:0] sum_sat(logic signed [63:0] s);
      return from_sm(s < 0, s < 0 ? -s : s);
    endfunction

    function logic signed [47:0] mul_fx(logic signed [47:0] a, logic signed [47:0] b);
      logic [127:0] p;
      logic [63:0]  q;
      p = mag(a) * mag(b);
      q = (p[127:80] != 0) ? '1 : p[79:16];
      return from_sm(a[47] != b[47], q);
    endfunction

    function logic signed [47:0] div_fx(logic signed [47:0] a, logic signed [47:0] b);
      if (b == 0) begin
        flag(ST_DIVZ);
        return 0;
      end
      return from_sm(a[47] != b[47], (mag(a) << FRAC_BITS) / mag(b));
    endfunction

    function void note_char(logic [7:0] c);
      rpn_result_t r;
      logic signed [47:0] l, rt, res;
      if (c == CH_END) begin
        r.value = 0;
        if (sp == 0) flag(ST_UNDER);
        else r.value = stk[sp-1];
        r.status = err;
        pending.push_back(r);
        sp = 0;
        err = ST_OK;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        if (sp >= DEPTH) flag(ST_OVER);
        else begin
          stk[sp] = 48'(c - CH_ZERO) << FRAC_BITS;
          sp++;
        end
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
        if (sp < 2) flag(ST_UNDER);
        else begin
          rt = stk[sp-1];
          l = stk[sp-2];
          case (c)
            CH_PLUS:  res = sum_sat(64'(l) + 64'(rt));
            CH_MINUS: res = sum_sat(64'(l) - 64'(rt));
            CH_STAR:  res = mul_fx(l, rt);
            default:  res = div_fx(l, rt);
          endcase
          sp--;
          stk[sp-1] = res;
        end
      end else flag(ST_BADCH);
    endfunction

    function void check_result(logic signed [47:0] v, status_t s);
      rpn_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result value=%0d status=%0d", v, s));
        return;
      end
      e = pending.pop_front();
      if (v !== e.value) report($sformatf("value %0d, want %0d", v, e.value));
      if (s !== e.status) report($sformatf("status %0d, want %0d", s, e.status));
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  pee_char_if   chars();
  pee_result_if results();
  rpn_scoreboard board = new();
  int hold_cycles = 0;
  int rx_wait = 0;
  int rx_draw;
  bit done = 0;

  always #1 clk = ~clk;

  postfix_expression_evaluator dut (.clk(clk), .rst(rst), .chars(chars), .results(results));

  initial begin
    chars.valid = 0;
    chars.char_code = 0;
    results.ready = 0;
  end

  // receiver: checks each taken result and may hold ready low before taking the next one
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 0;
      rx_wait <= 0;
    end else begin
      if (results.valid && results.ready)
        board.check_result(results.value, results.status);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        results.ready <= 0;
      end else if (results.valid && results.ready) begin
        rx_draw = $urandom_range(0, 3);
        rx_wait <= rx_draw;
        results.ready <= (rx_draw == 0);
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        results.ready <= (rx_wait == 1);
      end else begin
        results.ready <= 1;
      end
    end
  end

  task automatic send(logic [7:0] c, bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      chars.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    chars.valid <= 1;
    chars.char_code <= c;
    do @(posedge clk); while (!chars.ready);
    board.note_char(c);
  endtask

  task automatic send_str(string s, bit idle);
    foreach (s[i]) send(s[i], idle);
    send(CH_END, idle);
  endtask

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic drain();
    chars.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_expr(bit idle);
    int n, d, k;
    logic [7:0] c;
    n = $urandom_range(1, 12);
    d = 0;
    k = 0;
    while (k < n || d > 1) begin
      if ($urandom_range(0, 19) == 0) c = 8'($urandom_range(1, 255));
      else if (d < 2 || (k < n && $urandom_range(0, 1))) begin
        c = CH_ZERO + 8'($urandom_range(0, 9));
        d++;
        k++;
      end else begin
        c = rand_op();
        d--;
      end
      send(c, idle);
    end
    send(CH_END, idle);
  endtask

  initial begin
    int i;
    string s;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send_str("34+", 1);
    send_str("92-", 1);
    send_str("29-", 1);
    send_str("98*", 1);
    send_str("72/", 1);
    send_str("70-3/", 1);
    send_str("50/", 1);
    send_str("+", 1);
    send_str("", 1);
    send_str("4a", 1);
    send(8'hff, 1);
    send(8'h80, 1);
    send(8'h01, 1);
    send(CH_END, 1);
    s = "";
    repeat (16) s = {s, "9"};
    repeat (15) s = {s, "*"};
    send_str({s, "09-*"}, 1);
    send_str({s, "0", "9-", "+"}, 0);
    s = "";
    repeat (DEPTH + 2) s = {s, "7"};
    send_str(s, 1);
    send_str("19/9/9/9/9/9/9/", 0);
    drain();
    // long receiver hold while the sender keeps going
    hold_cycles = 200;
    for (i = 0; i < 20; i++) send_random_expr(0);
    drain();
    for (i = 0; i < 70; i++) begin
      send_random_expr($urandom_range(0, 3) != 0);
      if (i % 35 == 34) drain();
    end
    for (i = 0; i < 10; i++) send_random_expr(1);
    drain();
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
